>>> rtl/gcov_pkg.sv
// Shared types and constants for the greedy interval cover block.
// No dependencies.
package gcov_pkg;

  localparam int OPCODE_W = 2;
  localparam int COORD_W  = 32;
  localparam int PIECES_W = 11;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PIECES_W-1:0]       pieces_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TARGET = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SOLVE  = 2'd2
  } opcode_t;

endpackage

>>> rtl/gcov_in_if.sv
// Command channel of the greedy interval cover block: opcode and bounds.
// Depends on gcov_pkg.
interface gcov_in_if;
  import gcov_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  coord_t              low_point;
  coord_t              high_point;

  modport source (output valid, output opcode, output low_point, output high_point,
                  input ready);
  modport sink   (input valid, input opcode, input low_point, input high_point,
                  output ready);
endinterface

>>> rtl/gcov_out_if.sv
// Result channel of the greedy interval cover block: piece count and flag.
// Depends on gcov_pkg.
interface gcov_out_if;
  import gcov_pkg::*;

  logic    valid;
  logic    ready;
  pieces_t pieces_used;
  logic    possible;

  modport source (output valid, output pieces_used, output possible, input ready);
  modport sink   (input valid, input pieces_used, input possible, output ready);
endinterface

>>> rtl/greedy_interval_cover.sv
// Greedy interval cover: target and load beats are accepted one per cycle while idle.
// A solve runs passes over the interval RAM through its single read port: a test
// state, a read of every loaded interval, a drain of the last read and a decide step.
// The result beat and input ready return from S_DONE after the last pass, later
// while a previous result is stalled on out_ch.
// Reset (synchronous, active low) empties the store and zeroes the target.
module greedy_interval_cover #(
  parameter int MAX_INTERVALS = 1024
) (
  input logic     clk,
  input logic     rst_n,
  gcov_in_if.sink   in_ch,
  gcov_out_if.source out_ch
);
  import gcov_pkg::*;

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int EW = 2 * COORD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_SCAN,
    S_DONE
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  coord_t          tgt_start_r;
  coord_t          tgt_end_r;
  coord_t          point_r;
  logic [CW-1:0]   used_r;
  logic [CW-1:0]   idx_r;
  logic            rd_vld_r;
  logic            found_r;
  coord_t          best_r;
  logic            out_valid_r;
  pieces_t         pieces_r;
  logic            possible_r;

  logic            in_fire;
  logic            wr_en;
  logic            issue;
  logic [EW-1:0]   rd_data;
  coord_t          rd_start;
  coord_t          rd_end;
  logic            hit;
  logic            below_end;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign wr_en       = in_fire && (in_ch.opcode == OP_LOAD) &&
                       (count_r < CW'(MAX_INTERVALS));
  assign issue       = (state_r == S_SCAN) && (idx_r < count_r);

  assign rd_start  = rd_data[EW-1:COORD_W];
  assign rd_end    = rd_data[COORD_W-1:0];
  assign hit       = (rd_start <= point_r) && (point_r < rd_end);
  assign below_end = (point_r < tgt_end_r);

  gcov_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_INTERVALS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_ch.low_point, in_ch.high_point}),
    .re    (issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tgt_start_r <= '0;
      tgt_end_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.opcode == OP_TARGET) begin
              tgt_start_r <= in_ch.low_point;
              tgt_end_r   <= in_ch.high_point;
              count_r     <= '0;
            end else if (in_ch.opcode == OP_SOLVE) begin
              point_r <= tgt_start_r;
              used_r  <= '0;
              state_r <= S_TEST;
            end
            if (wr_en) begin
              count_r <= count_r + 1'b1;
            end
          end
        end
        S_TEST: begin
          idx_r    <= '0;
          found_r  <= 1'b0;
          rd_vld_r <= 1'b0;
          if (below_end && (used_r < count_r)) begin
            state_r <= S_SCAN;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SCAN: begin
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
          rd_vld_r <= issue;
          if (rd_vld_r && hit && (!found_r || (rd_end > best_r))) begin
            found_r <= 1'b1;
            best_r  <= rd_end;
          end
          if (!issue && !rd_vld_r) begin
            if (found_r) begin
              point_r <= best_r;
              used_r  <= used_r + 1'b1;
              state_r <= S_TEST;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            possible_r  <= !below_end;
            pieces_r    <= below_end ? '0 : PIECES_W'(used_r);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pieces_used = pieces_r;
  assign out_ch.possible    = possible_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !possible_r) |-> (pieces_r == '0))
    else $error("failed cover reports nonzero piece count");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> (used_r <= count_r))
    else $error("piece count exceeds loaded intervals");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN))
    else $error("read data pending outside scan");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside done state");

endmodule

>>> rtl/gcov_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gcov_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
